// ===== design/stepper_trapezoid_ramp_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp: assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp package
// Widths, codes, reset values and the rate scaling helper shared by the interfaces and modules.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Field and state widths
  localparam int POSITION_BITS  = 16;
  localparam int RATE_FRAC_BITS = 8;
  localparam int RATE_W         = 24;
  localparam int VAL_W          = 16;
  localparam int POS_OUT_W      = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int OP_W           = 2;

  // Derived widths
  localparam int DIST_W    = (POSITION_BITS > VAL_W) ? POSITION_BITS : VAL_W;
  localparam int SCALED_W  = CFG_W + RATE_FRAC_BITS;
  localparam int NUM_W     = SCALED_W + 4;
  localparam int CLAMP_W   = (NUM_W > RATE_W) ? NUM_W : RATE_W;
  localparam int DEN_W     = VAL_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int ZONE_W    = VAL_W + 4;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [VAL_W-1:0]  LEN_MAX  = {VAL_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] INITIAL_RATE_RST = 16'd500;
  localparam logic [CFG_W-1:0] TARGET_RATE_RST  = 16'd500;
  localparam logic [CFG_W-1:0] MAX_RATE_RST     = 16'hFFFF;

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_REL  = 2'd0,
    OP_ABS  = 2'd1,
    OP_TICK = 2'd2,
    OP_STOP = 2'd3
  } stp_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
  } stp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
  } stp_stat_t;

  // Scale a pulses-per-second value into the rate format, saturated
  function automatic logic [RATE_W-1:0] to_rate(input logic [CFG_W-1:0] pps);
    logic [CLAMP_W-1:0] v;
    v = CLAMP_W'(pps) << RATE_FRAC_BITS;
    if (v > CLAMP_W'(RATE_MAX)) begin
      v = CLAMP_W'(RATE_MAX);
    end
    return RATE_W'(v);
  endfunction

endpackage

// ===== design/stp_channels.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
interface stp_in_if;
  logic                        valid;
  logic                        ready;
  logic [stp_pkg::OP_W-1:0]    opcode;
  logic                        direction;
  logic [stp_pkg::VAL_W-1:0]   move_value;

  modport source (output valid, opcode, direction, move_value, input ready);
  modport sink   (input valid, opcode, direction, move_value, output ready);
endinterface

interface stp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           step_pulse;
  logic                           rate_valid;
  logic [stp_pkg::RATE_W-1:0]     step_rate;
  logic                           move_done;
  logic                           busy_res;
  logic [stp_pkg::POS_OUT_W-1:0]  position;

  modport source (output valid, step_pulse, rate_valid, step_rate, move_done, busy_res,
                  position, input ready);
  modport sink   (input valid, step_pulse, rate_valid, step_rate, move_done, busy_res,
                  position, output ready);
endinterface

// ===== design/stepper_trapezoid_ramp.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp
// Move generator with a linear trapezoidal step-rate ramp and a result register.
// ----------------------------------------------------------------------------
// Every item (step tick, limit stop, ignored start, zero-length start) gives
// one result beat from an output register, so items flow at one per cycle while
// the sink keeps up. A start with a nonzero length also launches the
// acceleration division on a bit-serial restoring divider that yields one
// quotient bit a cycle: in_ready stays low after such a start while the divider
// works out all 28 quotient bits and the clamped step is loaded.
// The start's own result beat is ready in the cycle after it is taken.
// ----------------------------------------------------------------------------
`include "stepper_trapezoid_ramp_macros.svh"

module stepper_trapezoid_ramp (
  input  logic                           clk,
  input  logic                           rst_n,
  stp_in_if.sink                         in_ch,
  stp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stp_pkg::CFG_W-1:0]      cfg_wdata
);

  stp_pkg::stp_cmd_t          cmd;
  stp_pkg::stp_stat_t         stat;
  logic                       need_div;
  logic                       div_busy;
  logic                       div_done;
  logic [stp_pkg::NUM_W-1:0]  div_numer;
  logic [stp_pkg::NUM_W-1:0]  div_quotient;
  logic [stp_pkg::DEN_W-1:0]  div_denom;

  assign stat.need_div = need_div;
  assign stat.div_done = div_done;

  // Sequence items and the result beat
  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Move state and ramp arithmetic
  stp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .opcode         (in_ch.opcode),
    .direction      (in_ch.direction),
    .move_value     (in_ch.move_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .need_div       (need_div),
    .div_done       (div_done),
    .div_quotient   (div_quotient),
    .div_numer      (div_numer),
    .div_denom      (div_denom),
    .res_step_pulse (out_ch.step_pulse),
    .res_rate_valid (out_ch.rate_valid),
    .res_step_rate  (out_ch.step_rate),
    .res_move_done  (out_ch.move_done),
    .res_busy       (out_ch.busy_res),
    .res_position   (out_ch.position)
  );

  // Acceleration divider
  stp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // No item may enter while the acceleration is still being worked out
  `STP_ASSERT_NOW(a_no_take_in_div, div_busy || div_done, !in_ch.ready, "item taken mid-division")
  // A start that needs a division must have the divider running next cycle
  `STP_ASSERT_NEXT(a_div_follows, cmd.div_start, div_busy, "divider did not start")
  // A finished move never asks for a timer reload
  `STP_ASSERT_NOW(a_done_no_rate, out_ch.valid && out_ch.move_done, !out_ch.rate_valid,
                  "rate reload on finished move")

endmodule

// ===== design/stp_divider.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp divider
// Restoring divider, one quotient bit per cycle, for the per-step acceleration.
// ----------------------------------------------------------------------------
module stp_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [stp_pkg::NUM_W-1:0]  numer,
  input  logic [stp_pkg::DEN_W-1:0]  denom,
  output logic                       busy,
  output logic                       done,
  output logic [stp_pkg::NUM_W-1:0]  quotient
);

  logic [stp_pkg::NUM_W-1:0]     quo_r, quo_nxt;
  logic [stp_pkg::DEN_W:0]       rem_r, rem_nxt;
  logic [stp_pkg::DEN_W-1:0]     den_r;
  logic [stp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [stp_pkg::DEN_W:0]       rem_sh;
  logic                          fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh   = {rem_r[stp_pkg::DEN_W-1:0], quo_r[stp_pkg::NUM_W-1]};
    fits     = rem_sh >= {1'b0, den_r};
    rem_nxt  = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_nxt  = {quo_r[stp_pkg::NUM_W-2:0], fits};
    cnt_nxt  = cnt_r - 1'b1;
    busy_nxt = busy_r && (cnt_r != stp_pkg::DIV_CNT_W'(1));
    done_nxt = busy_r && (cnt_r == stp_pkg::DIV_CNT_W'(1));
  end

  // Control: iteration count and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= stp_pkg::DIV_CNT_W'(stp_pkg::NUM_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Datapath: load operands, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/stp_datapath.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp datapath
// Move state, configuration registers, ramp arithmetic and the result register.
// ----------------------------------------------------------------------------
module stp_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  // item payload
  input  logic [stp_pkg::OP_W-1:0]       opcode,
  input  logic                           direction,
  input  logic [stp_pkg::VAL_W-1:0]      move_value,
  // configuration
  input  logic                           cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stp_pkg::CFG_W-1:0]      cfg_wdata,
  // controller link
  input  stp_pkg::stp_cmd_t              cmd,
  output logic                           need_div,
  // divider link
  input  logic                           div_done,
  input  logic [stp_pkg::NUM_W-1:0]      div_quotient,
  output logic [stp_pkg::NUM_W-1:0]      div_numer,
  output logic [stp_pkg::DEN_W-1:0]      div_denom,
  // result payload
  output logic                           res_step_pulse,
  output logic                           res_rate_valid,
  output logic [stp_pkg::RATE_W-1:0]     res_step_rate,
  output logic                           res_move_done,
  output logic                           res_busy,
  output logic [stp_pkg::POS_OUT_W-1:0]  res_position
);

  // Configuration registers
  logic [stp_pkg::CFG_W-1:0] initial_rate_r, target_rate_r, max_rate_r;

  // Move state
  logic [stp_pkg::POSITION_BITS-1:0] step_position_r, step_position_nxt;
  logic [stp_pkg::VAL_W-1:0]         steps_left_r, steps_left_nxt;
  logic [stp_pkg::VAL_W-1:0]         move_length_r, move_length_nxt;
  logic [stp_pkg::RATE_W-1:0]        rate_now_r, rate_now_nxt;
  logic [stp_pkg::RATE_W-1:0]        rate_step_r, rate_step_nxt;
  logic                              move_dir_r, move_dir_nxt;
  logic                              moving_r, moving_nxt;
  logic [stp_pkg::CFG_W-1:0]         cap_r;

  // Result register
  logic                           pulse_r, valid_r, done_r, busy_r;
  logic [stp_pkg::RATE_W-1:0]     rate_r;
  logic [stp_pkg::POS_OUT_W-1:0]  pos_r;
  logic                           pulse_nxt, valid_nxt, done_nxt;

  // Intermediate terms
  stp_pkg::stp_op_t              op;
  logic [stp_pkg::DIST_W-1:0]    pos_e, val_e, pos_gap;
  logic [stp_pkg::VAL_W-1:0]     len_start;
  logic [stp_pkg::VAL_W-1:0]     steps_dec;
  logic [stp_pkg::ZONE_W-1:0]    r10, l9, l1;
  logic [stp_pkg::RATE_W:0]      rate_sum;
  logic [stp_pkg::CFG_W-1:0]     rate_diff;
  logic [stp_pkg::NUM_W-1:0]     diff_scaled;
  logic [stp_pkg::CLAMP_W-1:0]   accel, cap_scaled;

  assign op = stp_pkg::stp_op_t'(opcode);

  // Move length of a start: step count, or distance to target saturated
  always_comb begin
    pos_e   = stp_pkg::DIST_W'(step_position_r);
    val_e   = stp_pkg::DIST_W'(move_value);
    pos_gap = (pos_e >= val_e) ? (pos_e - val_e) : (val_e - pos_e);
    if (op == stp_pkg::OP_ABS) begin
      len_start = (pos_gap > stp_pkg::DIST_W'(stp_pkg::LEN_MAX)) ? stp_pkg::LEN_MAX
                                                                  : stp_pkg::VAL_W'(pos_gap);
    end else begin
      len_start = move_value;
    end
  end

  // Acceleration dividend: (target - initial) scaled, times ten
  always_comb begin
    rate_diff   = (target_rate_r > initial_rate_r) ? (target_rate_r - initial_rate_r) : '0;
    diff_scaled = stp_pkg::NUM_W'(rate_diff) << stp_pkg::RATE_FRAC_BITS;
    div_numer   = (diff_scaled << 3) + (diff_scaled << 1);
    div_denom   = len_start;
  end

  // Ramp zone tests and saturating rate updates for a tick
  always_comb begin
    steps_dec = steps_left_r - 1'b1;
    r10       = (stp_pkg::ZONE_W'(steps_dec) << 3) + (stp_pkg::ZONE_W'(steps_dec) << 1);
    l1        = stp_pkg::ZONE_W'(move_length_r);
    l9        = (l1 << 3) + l1;
    rate_sum  = {1'b0, rate_now_r} + {1'b0, rate_step_r};
  end

  // Clamp the quotient to the acceleration cap and to the largest rate
  always_comb begin
    accel      = stp_pkg::CLAMP_W'(div_quotient);
    cap_scaled = stp_pkg::CLAMP_W'(cap_r) << stp_pkg::RATE_FRAC_BITS;
    if (accel > cap_scaled) begin
      accel = cap_scaled;
    end
    if (accel > stp_pkg::CLAMP_W'(stp_pkg::RATE_MAX)) begin
      accel = stp_pkg::CLAMP_W'(stp_pkg::RATE_MAX);
    end
  end

  // Next move state and result flags for the item
  always_comb begin
    step_position_nxt = step_position_r;
    steps_left_nxt    = steps_left_r;
    move_length_nxt   = move_length_r;
    rate_now_nxt      = rate_now_r;
    rate_step_nxt     = rate_step_r;
    move_dir_nxt      = move_dir_r;
    moving_nxt        = moving_r;
    pulse_nxt         = 1'b0;
    valid_nxt         = 1'b0;
    done_nxt          = 1'b0;
    need_div          = 1'b0;
    unique case (op)
      stp_pkg::OP_REL, stp_pkg::OP_ABS: begin
        if (!moving_r) begin
          move_dir_nxt    = direction;
          move_length_nxt = len_start;
          steps_left_nxt  = len_start;
          rate_now_nxt    = stp_pkg::to_rate(initial_rate_r);
          if (len_start != '0) begin
            moving_nxt = 1'b1;
            valid_nxt  = 1'b1;
            need_div   = 1'b1;
          end else begin
            rate_step_nxt = '0;
            done_nxt      = 1'b1;
          end
        end
      end
      stp_pkg::OP_TICK: begin
        if (moving_r) begin
          pulse_nxt         = 1'b1;
          step_position_nxt = move_dir_r ? (step_position_r + 1'b1)
                                         : (step_position_r - 1'b1);
          steps_left_nxt    = steps_dec;
          if (steps_dec == '0) begin
            moving_nxt = 1'b0;
            done_nxt   = 1'b1;
          end else if (r10 >= l9) begin
            rate_now_nxt = rate_sum[stp_pkg::RATE_W] ? stp_pkg::RATE_MAX
                                                     : rate_sum[stp_pkg::RATE_W-1:0];
            valid_nxt    = 1'b1;
          end else if (r10 <= l1) begin
            rate_now_nxt = (rate_now_r > rate_step_r) ? (rate_now_r - rate_step_r) : '0;
            valid_nxt    = 1'b1;
          end
        end
      end
      stp_pkg::OP_STOP: begin
        if (moving_r) begin
          moving_nxt = 1'b0;
          done_nxt   = 1'b1;
        end
      end
      default: begin
        moving_nxt = moving_r;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_rate_r <= stp_pkg::INITIAL_RATE_RST;
      target_rate_r  <= stp_pkg::TARGET_RATE_RST;
      max_rate_r     <= stp_pkg::MAX_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stp_pkg::CFG_INITIAL_RATE: initial_rate_r <= cfg_wdata;
        stp_pkg::CFG_TARGET_RATE:  target_rate_r  <= cfg_wdata;
        stp_pkg::CFG_MAX_RATE:     max_rate_r     <= cfg_wdata;
        default:                   max_rate_r     <= max_rate_r;
      endcase
    end
  end

  // Commit move state on a load; take the acceleration when division ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_position_r <= '0;
      steps_left_r    <= '0;
      move_length_r   <= '0;
      rate_now_r      <= '0;
      rate_step_r     <= '0;
      move_dir_r      <= 1'b0;
      moving_r        <= 1'b0;
    end else if (cmd.load) begin
      step_position_r <= step_position_nxt;
      steps_left_r    <= steps_left_nxt;
      move_length_r   <= move_length_nxt;
      rate_now_r      <= rate_now_nxt;
      rate_step_r     <= rate_step_nxt;
      move_dir_r      <= move_dir_nxt;
      moving_r        <= moving_nxt;
    end else if (div_done) begin
      rate_step_r <= stp_pkg::RATE_W'(accel);
    end
  end

  // Hold the cap for the running division
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      cap_r <= max_rate_r;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pulse_r <= pulse_nxt;
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
      busy_r  <= moving_nxt;
      rate_r  <= rate_now_nxt;
      pos_r   <= stp_pkg::POS_OUT_W'(step_position_nxt);
    end
  end

  assign res_step_pulse = pulse_r;
  assign res_rate_valid = valid_r;
  assign res_step_rate  = rate_r;
  assign res_move_done  = done_r;
  assign res_busy       = busy_r;
  assign res_position   = pos_r;

endmodule

// ===== design/stp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp controller
// Accepts items, owns the result valid flag and waits out the divider.
// ----------------------------------------------------------------------------
module stp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  stp_pkg::stp_stat_t stat,
  output stp_pkg::stp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // Take an item when idle and the result slot is free or draining
  assign in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept        = in_valid && in_ready;
  assign cmd.load      = accept;
  assign cmd.div_start = accept && stat.need_div;

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.need_div) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Set on a load, drop when the beat is taken
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
